FILE: rtl/qvr_pkg.sv
`default_nettype none

package qvr_pkg;

  // Three vector components travel side by side through the pipe
  localparam int LANES  = 3;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  // Per-word status carried alongside the divider remainders
  typedef struct packed {
    logic [LANES-1:0] neg;   // numerator of the lane is negative
    logic [LANES-1:0] ovf;   // quotient does not fit in DATA_WIDTH bits
    logic             zero;  // squared norm is zero
  } qvr_flags_t;

endpackage

`default_nettype wire

FILE: rtl/qvr_in_if.sv
`default_nettype none

interface qvr_in_if #(
  parameter int DATA_WIDTH = 16
) ();

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_w;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;
  logic signed [DATA_WIDTH-1:0] vec_x;
  logic signed [DATA_WIDTH-1:0] vec_y;
  logic signed [DATA_WIDTH-1:0] vec_z;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    input  ready
  );

  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/qvr_out_if.sv
`default_nettype none

interface qvr_out_if #(
  parameter int DATA_WIDTH = 16
) ();

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] rot_x;
  logic signed [DATA_WIDTH-1:0] rot_y;
  logic signed [DATA_WIDTH-1:0] rot_z;
  logic                         saturated;
  logic                         zero_quaternion;

  modport source (
    output valid, rot_x, rot_y, rot_z, saturated, zero_quaternion,
    input  ready
  );

  modport sink (
    input  valid, rot_x, rot_y, rot_z, saturated, zero_quaternion,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/qvr_terms.sv
`default_nettype none

module qvr_terms #(
  parameter  int DATA_WIDTH = 16,
  localparam int PW = 2 * DATA_WIDTH,
  localparam int SW = 2 * DATA_WIDTH + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] quat_w,
  input  logic signed [DATA_WIDTH-1:0] quat_x,
  input  logic signed [DATA_WIDTH-1:0] quat_y,
  input  logic signed [DATA_WIDTH-1:0] quat_z,
  input  logic signed [DATA_WIDTH-1:0] vec_x,
  input  logic signed [DATA_WIDTH-1:0] vec_y,
  input  logic signed [DATA_WIDTH-1:0] vec_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] w,
  output logic signed [DATA_WIDTH-1:0] u [qvr_pkg::LANES],
  output logic signed [DATA_WIDTH-1:0] v [qvr_pkg::LANES],
  output logic signed [SW-1:0]         norm,
  output logic signed [SW-1:0]         s,
  output logic signed [SW-1:0]         d,
  output logic signed [SW-1:0]         cr [qvr_pkg::LANES]
);

  import qvr_pkg::*;

  // First stage: operand copies, the squares of w, x, y, z and the products of x, y, z with the vector
  logic                         vld1;
  logic signed [DATA_WIDTH-1:0] w1;
  logic signed [DATA_WIDTH-1:0] u1 [LANES];
  logic signed [DATA_WIDTH-1:0] v1 [LANES];
  logic signed [PW-1:0]         p_ww;
  logic signed [PW-1:0]         p_uu [LANES];
  logic signed [PW-1:0]         p_uv [LANES];
  logic signed [PW-1:0]         p_yc, p_zb, p_za, p_xc, p_xb, p_ya;

  logic en1;
  logic en2;

  // Each stage loads when it is empty or its word moves on
  assign en2      = !out_valid || out_ready;
  assign en1      = !vld1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en1) begin
      vld1 <= in_valid;
    end
    if (en1) begin
      w1           <= quat_w;
      u1[LANE_X]   <= quat_x;
      u1[LANE_Y]   <= quat_y;
      u1[LANE_Z]   <= quat_z;
      v1[LANE_X]   <= vec_x;
      v1[LANE_Y]   <= vec_y;
      v1[LANE_Z]   <= vec_z;
      p_ww         <= PW'(quat_w) * PW'(quat_w);
      p_uu[LANE_X] <= PW'(quat_x) * PW'(quat_x);
      p_uu[LANE_Y] <= PW'(quat_y) * PW'(quat_y);
      p_uu[LANE_Z] <= PW'(quat_z) * PW'(quat_z);
      p_uv[LANE_X] <= PW'(quat_x) * PW'(vec_x);
      p_uv[LANE_Y] <= PW'(quat_y) * PW'(vec_y);
      p_uv[LANE_Z] <= PW'(quat_z) * PW'(vec_z);
      p_yc         <= PW'(quat_y) * PW'(vec_z);
      p_zb         <= PW'(quat_z) * PW'(vec_y);
      p_za         <= PW'(quat_z) * PW'(vec_x);
      p_xc         <= PW'(quat_x) * PW'(vec_z);
      p_xb         <= PW'(quat_x) * PW'(vec_y);
      p_ya         <= PW'(quat_y) * PW'(vec_x);
    end
  end

  // Second stage: norm, w^2 - u.u, u.v and u x v
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= vld1;
    end
    if (en2) begin
      w          <= w1;
      u          <= u1;
      v          <= v1;
      norm       <= SW'(p_ww) + SW'(p_uu[LANE_X]) + SW'(p_uu[LANE_Y]) + SW'(p_uu[LANE_Z]);
      s          <= SW'(p_ww) - SW'(p_uu[LANE_X]) - SW'(p_uu[LANE_Y]) - SW'(p_uu[LANE_Z]);
      d          <= SW'(p_uv[LANE_X]) + SW'(p_uv[LANE_Y]) + SW'(p_uv[LANE_Z]);
      cr[LANE_X] <= SW'(p_yc) - SW'(p_zb);
      cr[LANE_Y] <= SW'(p_za) - SW'(p_xc);
      cr[LANE_Z] <= SW'(p_xb) - SW'(p_ya);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/qvr_numer.sv
`default_nettype none

module qvr_numer #(
  parameter  int DATA_WIDTH = 16,
  localparam int SW = 2 * DATA_WIDTH + 2,
  localparam int NW = 3 * DATA_WIDTH + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] w,
  input  logic signed [DATA_WIDTH-1:0] u [qvr_pkg::LANES],
  input  logic signed [DATA_WIDTH-1:0] v [qvr_pkg::LANES],
  input  logic signed [SW-1:0]         norm,
  input  logic signed [SW-1:0]         s,
  input  logic signed [SW-1:0]         d,
  input  logic signed [SW-1:0]         cr [qvr_pkg::LANES],
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [NW-1:0]         num [qvr_pkg::LANES],
  output logic signed [SW-1:0]         norm_fwd
);

  import qvr_pkg::*;

  localparam int LW = 2 * DATA_WIDTH + 1;  // low-half partial product
  localparam int HW = 2 * DATA_WIDTH + 2;  // high-half partial product

  // Split the wide sums into an unsigned low half and a signed high half
  logic signed [DATA_WIDTH:0]   s_lo, d_lo;
  logic signed [DATA_WIDTH+1:0] s_hi, d_hi;
  logic signed [DATA_WIDTH:0]   c_lo [LANES];
  logic signed [DATA_WIDTH+1:0] c_hi [LANES];

  always_comb begin
    s_lo = {1'b0, s[DATA_WIDTH-1:0]};
    s_hi = s[SW-1:DATA_WIDTH];
    d_lo = {1'b0, d[DATA_WIDTH-1:0]};
    d_hi = d[SW-1:DATA_WIDTH];
    for (int k = 0; k < LANES; k++) begin
      c_lo[k] = {1'b0, cr[k][DATA_WIDTH-1:0]};
      c_hi[k] = cr[k][SW-1:DATA_WIDTH];
    end
  end

  logic vld_c, vld_d;
  logic en_c, en_d, en_e;

  assign en_e     = !out_valid || out_ready;
  assign en_d     = !vld_d || en_e;
  assign en_c     = !vld_c || en_d;
  assign in_ready = en_c;

  // Partial products: s*v, d*u and w*(u x v), each in two halves
  logic signed [LW-1:0] ps_lo [LANES], pd_lo [LANES], pw_lo [LANES];
  logic signed [HW-1:0] ps_hi [LANES], pd_hi [LANES], pw_hi [LANES];
  logic signed [SW-1:0] norm_c, norm_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
    end else if (en_c) begin
      vld_c <= in_valid;
    end
    if (en_c) begin
      norm_c <= norm;
      for (int k = 0; k < LANES; k++) begin
        ps_lo[k] <= LW'(s_lo) * LW'(v[k]);
        ps_hi[k] <= HW'(s_hi) * HW'(v[k]);
        pd_lo[k] <= LW'(d_lo) * LW'(u[k]);
        pd_hi[k] <= HW'(d_hi) * HW'(u[k]);
        pw_lo[k] <= LW'(c_lo[k]) * LW'(w);
        pw_hi[k] <= HW'(c_hi[k]) * HW'(w);
      end
    end
  end

  // Join the halves into full products
  logic signed [NW-1:0] fs [LANES], fd [LANES], fw [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
    end else if (en_d) begin
      vld_d <= vld_c;
    end
    if (en_d) begin
      norm_d <= norm_c;
      for (int k = 0; k < LANES; k++) begin
        fs[k] <= (NW'(ps_hi[k]) <<< DATA_WIDTH) + NW'(ps_lo[k]);
        fd[k] <= (NW'(pd_hi[k]) <<< DATA_WIDTH) + NW'(pd_lo[k]);
        fw[k] <= (NW'(pw_hi[k]) <<< DATA_WIDTH) + NW'(pw_lo[k]);
      end
    end
  end

  // Numerator: s*v + 2(u.v)u + 2w(u x v)
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_e) begin
      out_valid <= vld_d;
    end
    if (en_e) begin
      norm_fwd <= norm_d;
      for (int k = 0; k < LANES; k++) begin
        num[k] <= fs[k] + (fd[k] <<< 1) + (fw[k] <<< 1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/qvr_div_step.sv
`default_nettype none

module qvr_div_step #(
  parameter  int DATA_WIDTH = 16,
  parameter  int BIT = 0,
  localparam int DW = 3 * DATA_WIDTH + 3,
  localparam int VW = 2 * DATA_WIDTH + 2
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               in_valid,
  output logic                                               in_ready,
  input  logic [qvr_pkg::LANES-1:0][DW-1:0]                  rem,
  input  logic [qvr_pkg::LANES-1:0][DATA_WIDTH-1:0]          quo,
  input  logic [VW-1:0]                                      dsr,
  input  qvr_pkg::qvr_flags_t                                flg,
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output logic [qvr_pkg::LANES-1:0][DW-1:0]                  rem_fwd,
  output logic [qvr_pkg::LANES-1:0][DATA_WIDTH-1:0]          quo_fwd,
  output logic [VW-1:0]                                      dsr_fwd,
  output qvr_pkg::qvr_flags_t                                flg_fwd
);

  import qvr_pkg::*;

  logic [DW-1:0]         dsh;
  logic [DW:0]           diff [LANES];
  logic [DW-1:0]         rem_next [LANES];
  logic [DATA_WIDTH-1:0] quo_next [LANES];

  // Trial subtract of the divisor aligned to this quotient bit
  always_comb begin
    dsh = DW'(dsr) << BIT;
    for (int k = 0; k < LANES; k++) begin
      diff[k]          = {1'b0, rem[k]} - {1'b0, dsh};
      quo_next[k]      = quo[k];
      quo_next[k][BIT] = !diff[k][DW];
      rem_next[k]      = diff[k][DW] ? rem[k] : diff[k][DW-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready) begin
      dsr_fwd <= dsr;
      flg_fwd <= flg;
      for (int k = 0; k < LANES; k++) begin
        rem_fwd[k] <= rem_next[k];
        quo_fwd[k] <= quo_next[k];
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/qvr_round.sv
`default_nettype none

module qvr_round #(
  parameter  int DATA_WIDTH = 16,
  localparam int SW = 2 * DATA_WIDTH + 2,
  localparam int NW = 3 * DATA_WIDTH + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [NW-1:0]         num [qvr_pkg::LANES],
  input  logic signed [SW-1:0]         norm,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] rot [qvr_pkg::LANES],
  output logic                         saturated,
  output logic                         zero_quaternion
);

  import qvr_pkg::*;

  localparam int DW = NW;
  localparam int VW = 2 * DATA_WIDTH + 2;
  localparam logic [DATA_WIDTH:0] LIM_POS = {2'b00, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH:0] LIM_NEG = {2'b01, {(DATA_WIDTH-1){1'b0}}};

  logic en_f, en_g, en_h;

  // Dividend 2|n| + norm, one add or subtract per lane
  logic signed [DW:0] twice_n [LANES];
  logic signed [DW:0] nrm_x;
  logic signed [DW:0] dvd [LANES];

  always_comb begin
    nrm_x = (DW+1)'(norm);
    for (int k = 0; k < LANES; k++) begin
      twice_n[k] = (DW+1)'(num[k]) <<< 1;
      dvd[k]     = num[k][NW-1] ? nrm_x - twice_n[k] : nrm_x + twice_n[k];
    end
  end

  logic                       vld_f;
  logic [LANES-1:0][DW-1:0]   rem_f;
  logic [VW-1:0]              dsr_f;
  qvr_flags_t                 flg_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_f <= 1'b0;
    end else if (en_f) begin
      vld_f <= in_valid;
    end
    if (en_f) begin
      dsr_f      <= {norm[2*DATA_WIDTH:0], 1'b0};
      flg_f.zero <= (norm == '0);
      flg_f.ovf  <= '0;
      for (int k = 0; k < LANES; k++) begin
        rem_f[k]     <= dvd[k][DW-1:0];
        flg_f.neg[k] <= num[k][NW-1];
      end
    end
  end

  // Quotient too large for the output width
  logic                           vld_g;
  logic [LANES-1:0][DW-1:0]       rem_g;
  logic [VW-1:0]                  dsr_g;
  qvr_flags_t                     flg_g;
  logic [LANES-1:0]               ovf_next;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ovf_next[k] = rem_f[k] >= (DW'(dsr_f) << DATA_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_g <= 1'b0;
    end else if (en_g) begin
      vld_g <= vld_f;
    end
    if (en_g) begin
      rem_g      <= rem_f;
      dsr_g      <= dsr_f;
      flg_g.zero <= flg_f.zero;
      flg_g.neg  <= flg_f.neg;
      flg_g.ovf  <= ovf_next;
    end
  end

  // One quotient bit per stage, most significant first
  logic                                   vld_p [DATA_WIDTH+1];
  logic                                   rdy_p [DATA_WIDTH+1];
  logic [LANES-1:0][DW-1:0]               rem_p [DATA_WIDTH+1];
  logic [LANES-1:0][DATA_WIDTH-1:0]       quo_p [DATA_WIDTH+1];
  logic [VW-1:0]                          dsr_p [DATA_WIDTH+1];
  qvr_flags_t                             flg_p [DATA_WIDTH+1];

  assign vld_p[0] = vld_g;
  assign rem_p[0] = rem_g;
  assign quo_p[0] = '0;
  assign dsr_p[0] = dsr_g;
  assign flg_p[0] = flg_g;

  for (genvar j = 0; j < DATA_WIDTH; j++) begin : g_step
    qvr_div_step #(
      .DATA_WIDTH (DATA_WIDTH),
      .BIT        (DATA_WIDTH - 1 - j)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld_p[j]),
      .in_ready  (rdy_p[j]),
      .rem       (rem_p[j]),
      .quo       (quo_p[j]),
      .dsr       (dsr_p[j]),
      .flg       (flg_p[j]),
      .out_valid (vld_p[j+1]),
      .out_ready (rdy_p[j+1]),
      .rem_fwd   (rem_p[j+1]),
      .quo_fwd   (quo_p[j+1]),
      .dsr_fwd   (dsr_p[j+1]),
      .flg_fwd   (flg_p[j+1])
    );
  end

  assign en_h                = !out_valid || out_ready;
  assign rdy_p[DATA_WIDTH]   = en_h;
  assign en_g                = !vld_g || rdy_p[0];
  assign en_f                = !vld_f || en_g;
  assign in_ready            = en_f;

  // Clip to the signed range, restore the sign, force zero for a null quaternion
  qvr_flags_t                   flg_h;
  logic [DATA_WIDTH:0]          lim [LANES];
  logic [LANES-1:0]             clip;
  logic [DATA_WIDTH-1:0]        mag [LANES];
  logic signed [DATA_WIDTH-1:0] rot_next [LANES];

  always_comb begin
    flg_h = flg_p[DATA_WIDTH];
    for (int k = 0; k < LANES; k++) begin
      lim[k]      = flg_h.neg[k] ? LIM_NEG : LIM_POS;
      clip[k]     = flg_h.ovf[k] || ({1'b0, quo_p[DATA_WIDTH][k]} > lim[k]);
      mag[k]      = clip[k] ? lim[k][DATA_WIDTH-1:0] : quo_p[DATA_WIDTH][k];
      rot_next[k] = flg_h.zero ? '0 : (flg_h.neg[k] ? -mag[k] : mag[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_h) begin
      out_valid <= vld_p[DATA_WIDTH];
    end
    if (en_h) begin
      rot             <= rot_next;
      saturated       <= !flg_h.zero && (|clip);
      zero_quaternion <= flg_h.zero;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/quaternion_vector_rotate.sv
`default_nettype none

// Rotates a vector by a quaternion: each input word carries q = (w,x,y,z)
// and v, and the result word carries the vector part of q*(0,v)*q^-1 with
// q^-1 = conj(q)/|q|^2, so any non-zero quaternion gives a pure rotation.
// Values are signed fixed point (default Q1.14 in 16 bits); products are
// exact and the quotient is rounded once, to nearest with ties away from
// zero, then clipped to the signed DATA_WIDTH range with saturated set.
// A zero quaternion returns a zero vector with zero_quaternion set. The
// block is a pipeline that takes one word per cycle and returns one per
// cycle while result.ready stays high. Its stages are two product/sum stages,
// three numerator stages, two divider setup stages, one restoring-divider
// stage per quotient bit, and the output register.
// Each stage fills whenever it is empty, so bubbles close up under stall.
module quaternion_vector_rotate #(
  parameter int DATA_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  qvr_in_if.sink    item,
  qvr_out_if.source result
);

  import qvr_pkg::*;

  localparam int SW = 2 * DATA_WIDTH + 2;
  localparam int NW = 3 * DATA_WIDTH + 3;

  logic                         t_valid, t_ready;
  logic signed [DATA_WIDTH-1:0] t_w;
  logic signed [DATA_WIDTH-1:0] t_u [LANES];
  logic signed [DATA_WIDTH-1:0] t_v [LANES];
  logic signed [SW-1:0]         t_norm, t_s, t_d;
  logic signed [SW-1:0]         t_cr [LANES];

  qvr_terms #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_terms (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .quat_w    (item.quat_w),
    .quat_x    (item.quat_x),
    .quat_y    (item.quat_y),
    .quat_z    (item.quat_z),
    .vec_x     (item.vec_x),
    .vec_y     (item.vec_y),
    .vec_z     (item.vec_z),
    .out_valid (t_valid),
    .out_ready (t_ready),
    .w         (t_w),
    .u         (t_u),
    .v         (t_v),
    .norm      (t_norm),
    .s         (t_s),
    .d         (t_d),
    .cr        (t_cr)
  );

  logic                 n_valid, n_ready;
  logic signed [NW-1:0] n_num [LANES];
  logic signed [SW-1:0] n_norm;

  qvr_numer #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_numer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t_valid),
    .in_ready  (t_ready),
    .w         (t_w),
    .u         (t_u),
    .v         (t_v),
    .norm      (t_norm),
    .s         (t_s),
    .d         (t_d),
    .cr        (t_cr),
    .out_valid (n_valid),
    .out_ready (n_ready),
    .num       (n_num),
    .norm_fwd  (n_norm)
  );

  logic signed [DATA_WIDTH-1:0] rot [LANES];

  qvr_round #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_round (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (n_valid),
    .in_ready        (n_ready),
    .num             (n_num),
    .norm            (n_norm),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .rot             (rot),
    .saturated       (result.saturated),
    .zero_quaternion (result.zero_quaternion)
  );

  assign result.rot_x = rot[LANE_X];
  assign result.rot_y = rot[LANE_Y];
  assign result.rot_z = rot[LANE_Z];

endmodule

`default_nettype wire
